[design/mie_pkg.sv]
// ----------------------------------------------------------------------------
// mie_pkg: shared types and constants of the modular inverse block
// Controller states, the command/status bundles between controller and
// datapath, and the default width and modulus reset value.
// ----------------------------------------------------------------------------
`default_nettype none

package mie_pkg;

  localparam int WIDTH_DEF     = 16;
  localparam int MODULUS_RESET = 26;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_UPD,
    ST_FIX,
    ST_DONE
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic load;      // take a new item, seed the remainder and coefficient pairs
    logic div_init;  // start a quotient/remainder of r0 by r1
    logic div_step;  // one restoring division bit
    logic update;    // shift the Euclid pairs forward
    logic fix;       // normalize coefficient, decide on existence
    logic out_load;  // move the result into the output register
  } dp_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic r1_zero;   // current divisor is zero, the loop is over
  } dp_sts_t;

endpackage

`default_nettype wire

[design/mie_dpath.sv]
// ----------------------------------------------------------------------------
// mie_dpath: datapath of the modular inverse block
// Holds the modulus, the Euclid remainder and coefficient pairs, a
// one-bit-per-cycle restoring divider and the result/output registers.
// ----------------------------------------------------------------------------
`default_nettype none

module mie_dpath
  import mie_pkg::*;
#(
  parameter int WIDTH = WIDTH_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire dp_cmd_t          cmd,
  output dp_sts_t               sts,
  input  wire logic             cfg_we,
  input  wire logic [WIDTH-1:0] cfg_value,
  input  wire logic [WIDTH-1:0] value,
  output logic      [WIDTH-1:0] out_inv,
  output logic                  out_ok
);

  // coefficient width: magnitudes stay within the modulus, two spare bits
  localparam int TW = WIDTH + 2;

  logic        [WIDTH-1:0] modulus_r;
  logic        [WIDTH-1:0] r0_r, r1_r;
  logic signed [TW-1:0]    t0_r, t1_r;
  logic        [WIDTH-1:0] dvd_r, quo_r, rem_r;
  logic        [WIDTH-1:0] res_inv_r;
  logic                    res_ok_r;
  logic        [WIDTH-1:0] out_inv_r;
  logic                    out_ok_r;

  logic        [WIDTH:0]   trial;
  logic        [WIDTH:0]   trial_sub;
  logic                    qbit;
  logic signed [2*TW-1:0]  prod;
  logic signed [TW-1:0]    tt;
  logic signed [TW-1:0]    mod_s;
  logic signed [TW-1:0]    t0_norm;
  logic                    ok_now;

  // restoring division bit
  assign trial     = {rem_r, dvd_r[WIDTH-1]};
  assign trial_sub = trial - {1'b0, r1_r};
  assign qbit      = !trial_sub[WIDTH];

  // next coefficient: t0 - q * t1
  assign prod = $signed({{(TW-WIDTH){1'b0}}, quo_r}) * t1_r;
  assign tt   = t0_r - $signed(prod[TW-1:0]);

  assign mod_s = $signed({{(TW-WIDTH){1'b0}}, modulus_r});

  always_comb begin
    if (t0_r[TW-1]) begin
      t0_norm = t0_r + mod_s;
    end else if (t0_r >= mod_s) begin
      t0_norm = t0_r - mod_s;
    end else begin
      t0_norm = t0_r;
    end
  end

  assign ok_now = (modulus_r > WIDTH'(1)) && (r0_r == WIDTH'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r <= WIDTH'(MODULUS_RESET);
    end else if (cfg_we) begin
      modulus_r <= cfg_value;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      // seed with (value, modulus): the first step reduces value mod modulus
      r0_r <= value;
      r1_r <= modulus_r;
      t0_r <= TW'(1);
      t1_r <= '0;
    end else if (cmd.update) begin
      r0_r <= r1_r;
      r1_r <= rem_r;
      t0_r <= t1_r;
      t1_r <= tt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      dvd_r <= r0_r;
      rem_r <= '0;
      quo_r <= '0;
    end else if (cmd.div_step) begin
      dvd_r <= {dvd_r[WIDTH-2:0], 1'b0};
      quo_r <= {quo_r[WIDTH-2:0], qbit};
      rem_r <= qbit ? trial_sub[WIDTH-1:0] : trial[WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_ok_r <= 1'b0;
    end else if (cmd.fix) begin
      res_ok_r <= ok_now;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fix) begin
      res_inv_r <= ok_now ? t0_norm[WIDTH-1:0] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_inv_r <= res_inv_r;
      out_ok_r  <= res_ok_r;
    end
  end

  assign sts.r1_zero = (r1_r == '0);
  assign out_inv     = out_inv_r;
  assign out_ok      = out_ok_r;

  // a division never runs against a zero divisor
  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_step |-> (r1_r != '0))
    else $error("division step with zero divisor");

  // the partial remainder stays below the divisor
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_step |=> (rem_r < r1_r))
    else $error("partial remainder not below divisor");

  // zero is never anyone's inverse
  a_inv_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    res_ok_r |-> (res_inv_r != '0))
    else $error("inverse flagged but zero");

endmodule

`default_nettype wire

[design/mie_ctrl.sv]
// ----------------------------------------------------------------------------
// mie_ctrl: controller of the modular inverse block
// Sequences load, Euclid steps (division bits plus one update), the final
// fix-up and the hand-off to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mie_ctrl
  import mie_pkg::*;
#(
  parameter int WIDTH = WIDTH_DEF
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_tvalid,
  output logic         in_tready,
  output logic         out_tvalid,
  input  wire logic    out_tready,
  output dp_cmd_t      cmd,
  input  wire dp_sts_t sts
);

  localparam int CNT_W = $clog2(WIDTH);

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               cnt_last;

  assign cnt_last = (cnt_r == CNT_W'(WIDTH - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    cmd           = '0;
    in_tready     = 1'b0;
    out_valid_nxt = out_valid_r && !out_tready;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (sts.r1_zero) begin
          state_nxt = ST_FIX;
        end else begin
          cmd.div_init = 1'b1;
          cnt_nxt      = '0;
          state_nxt    = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + CNT_W'(1);
        if (cnt_last) begin
          state_nxt = ST_UPD;
        end
      end
      ST_UPD: begin
        cmd.update = 1'b1;
        state_nxt  = ST_CHECK;
      end
      ST_FIX: begin
        cmd.fix   = 1'b1;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        // hold until the output register is free
        if (!out_valid_r || out_tready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_tvalid = out_valid_r;

  a_accept_check: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == ST_CHECK))
    else $error("accepted item did not start the loop");

  a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV && cnt_last) |=> (state_r == ST_UPD))
    else $error("division did not end after WIDTH bits");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_tready))
    else $error("output register overwritten while pending");

endmodule

`default_nettype wire

[design/modular_inverse_ext_euclid.sv]
// ----------------------------------------------------------------------------
// modular_inverse_ext_euclid: modular inverse by the extended Euclid method
// Inverts each input item modulo the configured modulus; flags when none.
// ----------------------------------------------------------------------------
// Sequence: accept, then per Euclid step a check, WIDTH restoring-division
//   bits and an update, then a final check, fix-up and output load; at most
//   23 steps for WIDTH=16 (one extra step reduces value mod modulus).
// Throughput: one item at a time, set by the shared bit-serial divider;
//   the next item is taken while a finished result waits in the output reg.
// Reset (rst_n low, synchronous): controller idle, no result pending,
//   modulus back to 26.
`default_nettype none

module modular_inverse_ext_euclid
  import mie_pkg::*;
#(
  parameter int WIDTH = WIDTH_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  // input items
  input  wire logic                      in_tvalid,
  output logic                           in_tready,
  input  wire logic [((WIDTH+7)/8)*8-1:0] in_tdata,   // [WIDTH-1:0] value
  // result items
  output logic                           out_tvalid,
  input  wire logic                      out_tready,
  output logic [((WIDTH+7)/8)*8-1:0]     out_tdata,  // [WIDTH-1:0] inverse
  output logic                           out_tuser,  // [0] has_inverse
  // modulus register write
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [WIDTH-1:0]          cfg_data
);

  localparam int DW = ((WIDTH + 7) / 8) * 8;

  dp_cmd_t           cmd;
  dp_sts_t           sts;
  logic [WIDTH-1:0]  inv;
  logic              ok;

  // modulus writes must arrive only while idle; the block does not enforce it and always takes them
  assign cfg_ready = 1'b1;

  mie_ctrl #(
    .WIDTH (WIDTH)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .sts        (sts)
  );

  mie_dpath #(
    .WIDTH (WIDTH)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .cfg_we    (cfg_valid),
    .cfg_value (cfg_data),
    .value     (in_tdata[WIDTH-1:0]),
    .out_inv   (inv),
    .out_ok    (ok)
  );

  // zero-fill the inverse up to a whole number of bytes
  assign out_tdata = DW'(inv);
  assign out_tuser = ok;

endmodule

`default_nettype wire

[sim/modular_inverse_ext_euclid_check.sv]
// ----------------------------------------------------------------------------
// modular_inverse_ext_euclid_check: result checker for the modular inverse
// Watches the modulus, input and result channels. It predicts each inverse
// from its own copy of the modulus and compares every result in order.
// ----------------------------------------------------------------------------
module modular_inverse_ext_euclid_check
  import mie_pkg::*;
#(
  parameter int WIDTH = WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  input  logic                           in_tready,
  input  logic [((WIDTH+7)/8)*8-1:0]     in_tdata,   // [WIDTH-1:0] value
  input  logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic [((WIDTH+7)/8)*8-1:0]     out_tdata,  // [WIDTH-1:0] inverse
  input  logic                           out_tuser,  // [0] has_inverse
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [WIDTH-1:0]               cfg_data,
  output int                             pending,
  output int                             failures,
  output int                             checked,
  output int                             invertible
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [WIDTH-1:0] inverse;
    logic             has_inverse;
  } inverse_item_t;

  inverse_item_t    expected_inverses[$];
  logic [WIDTH-1:0] modulus_copy = WIDTH'(MODULUS_RESET);
  int               fail_tally;
  int               check_tally;
  int               invert_tally;

  // Extended Euclid with the loop bounded by the operand width.
  function automatic inverse_item_t predict_inverse(input logic [WIDTH-1:0] v,
                                                    input logic [WIDTH-1:0] m);
    inverse_item_t    res;
    longint unsigned  r0, r1, q, rt;
    longint           t0, t1, tt, m_s;
    int               step;
    res = '0;
    if (m < 2) return res;
    m_s = longint'(m);
    r0  = 64'(m);
    r1  = 64'(v % m);
    t0  = 0;
    t1  = 1;
    for (step = 0; step < 2 * WIDTH + 2 && r1 != 0; step++) begin
      q  = r0 / r1;
      rt = r0 - q * r1;
      r0 = r1;
      r1 = rt;
      tt = t0 - longint'(q) * t1;
      t0 = t1;
      t1 = tt;
    end
    if (r0 != 1) return res;
    while (t0 < 0) t0 += m_s;
    while (t0 >= m_s) t0 -= m_s;
    res.inverse     = t0[WIDTH-1:0];
    res.has_inverse = 1'b1;
    return res;
  endfunction

  always @(posedge clk) begin
    inverse_item_t want;
    if (!rst_n) begin
      modulus_copy = WIDTH'(MODULUS_RESET);
      expected_inverses.delete();
    end else begin
      if (cfg_valid && cfg_ready) modulus_copy = cfg_data;
      // check results before queuing new work, so a stray result is never hidden
      if (out_tvalid && out_tready) begin
        if (expected_inverses.size() == 0) begin
          $error("result with no item outstanding: inverse %0d has_inverse %0d",
                 out_tdata[WIDTH-1:0], out_tuser);
          fail_tally++;
        end else begin
          want = expected_inverses.pop_front();
          check_tally++;
          if (want.has_inverse) invert_tally++;
          if (out_tdata[WIDTH-1:0] !== want.inverse) begin
            $error("inverse: expected %0d, actual %0d", want.inverse,
                   out_tdata[WIDTH-1:0]);
            fail_tally++;
          end
          if (out_tuser !== want.has_inverse) begin
            $error("has_inverse: expected %0d, actual %0d", want.has_inverse,
                   out_tuser);
            fail_tally++;
          end
        end
      end
      if (in_tvalid && in_tready)
        expected_inverses.push_back(predict_inverse(in_tdata[WIDTH-1:0], modulus_copy));
    end
    pending    <= expected_inverses.size();
    failures   <= fail_tally;
    checked    <= check_tally;
    invertible <= invert_tally;
  end

endmodule

[sim/modular_inverse_ext_euclid_test.sv]
// ----------------------------------------------------------------------------
// modular_inverse_ext_euclid_test: testbench top for the modular inverse
// Drives directed and random values under a series of modulus settings,
// with random gaps on both channels and one long result stall; the checker
// beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module modular_inverse_ext_euclid_test;
  import mie_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int W           = WIDTH_DEF;
  localparam int TW          = ((W + 7) / 8) * 8;
  localparam int RAND_PHASES = 14;
  localparam int PHASE_ITEMS = 100;
  // long receiver stall: start after this many results, hold this many cycles
  localparam int HOLD_AT     = 300;
  localparam int HOLD_CYCLES = 3000;
  // worst item is at most 23 Euclid steps plus the finish; allow margin
  localparam int DRAIN_CYCLES = 600;
  localparam int CYCLE_LIMIT  = 3_000_000;

  logic          clk        = 1'b0;
  logic          rst_n      = 1'b0;
  logic          in_tvalid  = 1'b0;
  logic          in_tready;
  logic [TW-1:0] in_tdata   = '0;
  logic          out_tvalid;
  logic          out_tready = 1'b0;
  logic [TW-1:0] out_tdata;
  logic          out_tuser;
  logic          cfg_valid  = 1'b0;
  logic          cfg_ready;
  logic [W-1:0]  cfg_data   = '0;

  int pending;
  int failures;
  int checked;
  int invertible;

  bit          calm = 1'b0;     // both sides run without gaps while set
  int          settings = 1;    // modulus settings used, reset value counts
  logic [W-1:0] modulus_now = W'(MODULUS_RESET);
  int          cycle_count = 0;

  always #5 clk = ~clk;

  always @(posedge clk) cycle_count <= cycle_count + 1;

  modular_inverse_ext_euclid #(
    .WIDTH(W)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  modular_inverse_ext_euclid_check #(
    .WIDTH(W)
  ) u_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .pending   (pending),
    .failures  (failures),
    .checked   (checked),
    .invertible(invertible)
  );

  // Offer one value, after a random gap; leave tvalid high on return so a
  // back-to-back item needs no second assignment in the same step.
  task automatic send_value(input logic [W-1:0] v);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= TW'(v);
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Drop tvalid and wait until the checker holds no expectation.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Write the modulus after draining every result, so the block has gone idle.
  task automatic write_modulus(input logic [W-1:0] m);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data  <= m;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid   <= 1'b0;
    modulus_now = m;
    settings++;
  endtask

  // Mix of plain random, reduced, common-factor, extreme and oversized values.
  function automatic logic [W-1:0] pick_value(input logic [W-1:0] m);
    int          f;
    int unsigned v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: v = $urandom;
      5, 6: v = (m > 0) ? $urandom_range(0, m - 1) : 0;
      7: begin
        f = $urandom_range(2, 7);
        v = f * $urandom_range(0, 65535 / f);
      end
      8: begin
        case ($urandom_range(0, 4))
          0: v = 0;
          1: v = 1;
          2: v = m - 1;
          3: v = 32'(m);
          default: v = 2 ** W - 1;
        endcase
      end
      default: v = int'(m) + $urandom_range(0, m);
    endcase
    return v[W-1:0];
  endfunction

  function automatic logic [W-1:0] pick_modulus(input int phase);
    case (phase)
      0: return 16'hFFFF;
      1: return 16'd2;
      2: return 16'd65521;
      3: return W'(MODULUS_RESET);
      default: begin
        case ($urandom_range(0, 3))
          0, 1: return W'($urandom_range(2, 65535));
          2: return W'($urandom_range(2, 300));
          default: return W'(2 * $urandom_range(1, 32767));
        endcase
      end
    endcase
  endfunction

  // Receiver: random stall before each result, one long hold-off to fill
  // the block and back-pressure the input side.
  initial begin : receiver
    int stall;
    int taken;
    taken = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 8);
      if (taken == HOLD_AT) stall = HOLD_CYCLES;
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      taken++;
    end
  end

  // Hard stop on a hung block or lost results.
  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
    $display("modular_inverse_ext_euclid_test NOT OK");
    $finish;
  end

  initial begin : stimulus
    int phase;
    int n;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset modulus 26: zero, one, top of range, the modulus itself, beyond it,
    // a shared factor, and alternating bit patterns
    send_value(16'd0);
    send_value(16'd1);
    send_value(16'd25);
    send_value(16'd26);
    send_value(16'd27);
    send_value(16'd13);
    send_value(16'd2);
    send_value(16'hFFFF);
    send_value(16'hAAAA);
    send_value(16'h5555);

    // out-of-range moduli zero and one never give an inverse
    write_modulus(16'd0);
    send_value(16'd0);
    send_value(16'd1);
    send_value(16'd5);
    write_modulus(16'd1);
    send_value(16'd0);
    send_value(16'd3);

    // smallest legal modulus
    write_modulus(16'd2);
    send_value(16'd0);
    send_value(16'd1);
    send_value(16'd3);

    // largest modulus
    write_modulus(16'hFFFF);
    send_value(16'hFFFE);
    send_value(16'hFFFF);
    send_value(16'd2);

    // consecutive Fibonacci numbers take the most Euclid steps
    write_modulus(16'd46368);
    send_value(16'd28657);
    send_value(16'd17711);

    // random phases, each under its own modulus; every fourth runs gap-free
    for (phase = 0; phase < RAND_PHASES; phase++) begin
      write_modulus(pick_modulus(phase));
      calm = (phase % 4 == 3);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        send_value(pick_value(modulus_now));
        // pause mid-phase once until every result is back
        if (phase == 5 && n == PHASE_ITEMS / 2) drain_results();
      end
    end
    calm = 1'b0;

    // wait for the last results, then watch for strays
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("checked %0d results under %0d modulus settings, moduli 0, 1, 2 and 65535 included",
             checked, settings);
    $display("%0d results had an inverse, %0d had none", invertible, checked - invertible);
    if (failures == 0) begin
      $display("modular_inverse_ext_euclid_test OK");
    end else begin
      $display("modular_inverse_ext_euclid_test NOT OK");
    end
    $finish;
  end

endmodule
